@@ hdl/sbpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_pkg: shared types and constants of the servo bus packet framer
// Byte codes, packet lengths, register indexes and the packet descriptor that
// travels from the front part to the back part through the queue.
// ----------------------------------------------------------------------------
package sbpf_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int MAX_SERVOS = 32;
    localparam int NBYTES     = 12;                    // longest body without checksum
    localparam int NB_W       = $clog2(NBYTES + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int HDR_SKIP   = 2;                     // FF FF stay out of the checksum

    localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'hFF;
    localparam logic [BYTE_W-1:0] BROADCAST_ID  = 8'hFE;
    localparam logic [BYTE_W-1:0] SYNC_DATA_LEN = 8'h06;
    localparam logic [BYTE_W-1:0] SHORT_LEN     = 8'h04;
    localparam logic [BYTE_W-1:0] POS_LEN       = 8'h09;
    localparam logic [BYTE_W-1:0] SYNC_LEN_BASE = 8'h04;

    localparam logic [BYTE_W-1:0] RST_WRITE_OPCODE     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_SYNC_OPCODE      = 8'd131;
    localparam logic [BYTE_W-1:0] RST_POSITION_ADDRESS = 8'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_OPCODE     = 2'd0,
        CFG_SYNC_OPCODE      = 2'd1,
        CFG_POSITION_ADDRESS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_SHORT  = 2'd0,
        ACT_POS    = 2'd1,
        ACT_SSTART = 2'd2,
        ACT_SREC   = 2'd3
    } t_action;

    // Which running sum a descriptor feeds and closes.
    typedef enum logic [1:0] {
        SUM_PKT    = 2'd0,
        SUM_SSTART = 2'd1,
        SUM_SREC   = 2'd2
    } t_sum_sel;

    typedef struct packed {
        logic [BYTE_W-1:0] write_opcode;
        logic [BYTE_W-1:0] sync_opcode;
        logic [BYTE_W-1:0] position_address;
    } t_cfg;

    typedef struct packed {
        logic [NBYTES-1:0][BYTE_W-1:0] bytes;   // bytes[0] goes out first
        logic [NB_W-1:0]               nbytes;
        logic                          cs;      // append checksum after the body
        logic                          hdr;     // body opens with FF FF
        t_sum_sel                      sel;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_out;

endpackage

@@ hdl/sbpf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_in_if: command channel of the servo bus packet framer
// Valid/ready handshake with one framing request per transfer.
// ----------------------------------------------------------------------------
interface sbpf_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [sbpf_pkg::BYTE_W-1:0]    servo_id;
    logic [sbpf_pkg::BYTE_W-1:0]    instruction;
    logic [sbpf_pkg::BYTE_W-1:0]    register_address;
    logic [sbpf_pkg::BYTE_W-1:0]    parameter_byte;
    logic [15:0]                    position;
    logic [15:0]                    move_time;
    logic [15:0]                    speed;
    logic [sbpf_pkg::CNT_W-1:0]     servo_count;

    modport source (
        output valid, action, servo_id, instruction, register_address, parameter_byte,
               position, move_time, speed, servo_count,
        input  ready
    );
    modport sink (
        input  valid, action, servo_id, instruction, register_address, parameter_byte,
               position, move_time, speed, servo_count,
        output ready
    );
endinterface

@@ hdl/sbpf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_out_if: byte channel of the servo bus packet framer
// Valid/ready handshake with one transmit byte per transfer.
// ----------------------------------------------------------------------------
interface sbpf_out_if;
    logic                           valid;
    logic                           ready;
    logic [sbpf_pkg::BYTE_W-1:0]    tx_byte;
    logic                           run_last;
    logic                           frame_end;

    modport source (output valid, tx_byte, run_last, frame_end, input ready);
    modport sink   (input valid, tx_byte, run_last, frame_end, output ready);
endinterface

@@ hdl/sbpf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_front: request decoder of the servo bus packet framer
// Accepts requests, tracks the open sync write and builds packet descriptors.
// ----------------------------------------------------------------------------
module sbpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbpf_in_if.sink           i_cmd,
    input  sbpf_pkg::t_cfg    i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output sbpf_pkg::t_desc   o_desc
);
    import sbpf_pkg::*;

    logic [CNT_W-1:0]  r_left;
    logic              r_open;
    logic [CNT_W-1:0]  w_cnt;
    logic [BYTE_W-1:0] w_cnt8;
    logic [BYTE_W-1:0] w_len;
    logic              w_acc;
    logic              w_rec_ok;
    t_desc             w_desc;
    logic              w_push;

    assign i_cmd.ready = !i_q_full;
    assign w_acc       = i_cmd.valid && !i_q_full;

    assign w_cnt    = (i_cmd.servo_count > CNT_W'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS)
                                                               : i_cmd.servo_count;
    assign w_cnt8   = BYTE_W'(w_cnt);
    assign w_len    = (w_cnt8 << 3) - w_cnt8 + SYNC_LEN_BASE;
    assign w_rec_ok = r_open && (r_left != '0);

    always_comb begin
        w_desc = '0;
        w_push = 1'b1;
        unique case (t_action'(i_cmd.action))
            ACT_SHORT: begin
                w_desc.bytes[0] = HDR_BYTE;
                w_desc.bytes[1] = HDR_BYTE;
                w_desc.bytes[2] = i_cmd.servo_id;
                w_desc.bytes[3] = SHORT_LEN;
                w_desc.bytes[4] = i_cmd.instruction;
                w_desc.bytes[5] = i_cmd.register_address;
                w_desc.bytes[6] = i_cmd.parameter_byte;
                w_desc.nbytes   = NB_W'(7);
                w_desc.cs       = 1'b1;
                w_desc.hdr      = 1'b1;
                w_desc.sel      = SUM_PKT;
            end
            ACT_POS: begin
                w_desc.bytes[0]  = HDR_BYTE;
                w_desc.bytes[1]  = HDR_BYTE;
                w_desc.bytes[2]  = i_cmd.servo_id;
                w_desc.bytes[3]  = POS_LEN;
                w_desc.bytes[4]  = i_cfg.write_opcode;
                w_desc.bytes[5]  = i_cfg.position_address;
                w_desc.bytes[6]  = i_cmd.position[15:8];
                w_desc.bytes[7]  = i_cmd.position[7:0];
                w_desc.bytes[8]  = i_cmd.move_time[15:8];
                w_desc.bytes[9]  = i_cmd.move_time[7:0];
                w_desc.bytes[10] = i_cmd.speed[15:8];
                w_desc.bytes[11] = i_cmd.speed[7:0];
                w_desc.nbytes    = NB_W'(12);
                w_desc.cs        = 1'b1;
                w_desc.hdr       = 1'b1;
                w_desc.sel       = SUM_PKT;
            end
            ACT_SSTART: begin
                w_desc.bytes[0] = HDR_BYTE;
                w_desc.bytes[1] = HDR_BYTE;
                w_desc.bytes[2] = BROADCAST_ID;
                w_desc.bytes[3] = w_len;
                w_desc.bytes[4] = i_cfg.sync_opcode;
                w_desc.bytes[5] = i_cfg.position_address;
                w_desc.bytes[6] = SYNC_DATA_LEN;
                w_desc.nbytes   = NB_W'(7);
                w_desc.cs       = (w_cnt == '0);
                w_desc.hdr      = 1'b1;
                w_desc.sel      = SUM_SSTART;
            end
            ACT_SREC: begin
                w_desc.bytes[0] = i_cmd.servo_id;
                w_desc.bytes[1] = i_cmd.position[15:8];
                w_desc.bytes[2] = i_cmd.position[7:0];
                w_desc.bytes[3] = i_cmd.move_time[15:8];
                w_desc.bytes[4] = i_cmd.move_time[7:0];
                w_desc.bytes[5] = i_cmd.speed[15:8];
                w_desc.bytes[6] = i_cmd.speed[7:0];
                w_desc.nbytes   = NB_W'(7);
                w_desc.cs       = (r_left == CNT_W'(1));
                w_desc.hdr      = 1'b0;
                w_desc.sel      = SUM_SREC;
                w_push          = w_rec_ok;
            end
        endcase
    end

    assign o_desc = w_desc;
    assign o_push = w_acc && w_push;

    // Track the open sync write: start arms it, each record counts down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_open <= 1'b0;
        end else if (w_acc) begin
            if (t_action'(i_cmd.action) == ACT_SSTART) begin
                r_left <= w_cnt;
                r_open <= (w_cnt != '0);
            end else if (t_action'(i_cmd.action) == ACT_SREC && w_rec_ok) begin
                r_left <= r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    r_open <= 1'b0;
                end
            end
        end
    end

endmodule

@@ hdl/sbpf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_queue: descriptor queue between decoder and byte sequencer
// Small first-in first-out store that lets each side stall on its own.
// ----------------------------------------------------------------------------
module sbpf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbpf_pkg::t_desc   i_desc,
    input  logic              i_pop,
    output logic              o_full,
    output sbpf_pkg::t_q_out  o_q
);
    import sbpf_pkg::*;

    t_desc               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_pop;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.desc   = r_mem[r_rd];
    assign w_pop      = i_pop && o_q.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/sbpf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_back: byte sequencer of the servo bus packet framer
// Shifts descriptor bytes out one a cycle unless the output stalls, keeps the checksums, drives output.
// ----------------------------------------------------------------------------
module sbpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbpf_pkg::t_q_out  i_q,
    output logic              o_pop,
    sbpf_out_if.source        o_tx
);
    import sbpf_pkg::*;

    logic                          r_busy;
    logic [NBYTES-1:0][BYTE_W-1:0] r_bytes;
    logic [NB_W-1:0]               r_left;
    logic [NB_W-1:0]               r_idx;
    logic                          r_cs;
    logic                          r_hdr;
    t_sum_sel                      r_sel;
    logic [BYTE_W-1:0]             r_pkt_sum;
    logic [BYTE_W-1:0]             r_sync_sum;
    logic                          r_out_valid;
    logic [BYTE_W-1:0]             r_out_byte;
    logic                          r_out_last;
    logic                          r_out_fe;

    logic [BYTE_W-1:0]             n_pkt_sum;
    logic [BYTE_W-1:0]             n_sync_sum;
    logic                          w_adv;
    logic                          w_emit;
    logic                          w_data;
    logic                          w_last;
    logic                          w_load;
    logic                          w_counted;
    logic [BYTE_W-1:0]             w_sum;
    logic [BYTE_W-1:0]             w_byte;

    assign w_adv     = !r_out_valid || o_tx.ready;
    assign w_emit    = r_busy && w_adv;
    assign w_data    = (r_left != '0);
    assign w_last    = w_data ? (r_left == NB_W'(1) && !r_cs) : 1'b1;
    assign w_load    = (!r_busy || (w_emit && w_last)) && i_q.valid;
    assign w_counted = !(r_hdr && r_idx < NB_W'(HDR_SKIP));
    assign w_sum     = (r_sel == SUM_PKT) ? r_pkt_sum : r_sync_sum;
    assign w_byte    = w_data ? r_bytes[0] : ~w_sum;
    assign o_pop     = w_load;

    // Accumulate the byte being sent; a new descriptor clears the sum it opens.
    always_comb begin
        n_pkt_sum  = r_pkt_sum;
        n_sync_sum = r_sync_sum;
        if (w_emit && w_data && w_counted) begin
            if (r_sel == SUM_PKT) begin
                n_pkt_sum = r_pkt_sum + r_bytes[0];
            end else begin
                n_sync_sum = r_sync_sum + r_bytes[0];
            end
        end
        if (w_load) begin
            case (i_q.desc.sel)
                SUM_PKT:    n_pkt_sum  = '0;
                SUM_SSTART: n_sync_sum = '0;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pkt_sum   <= '0;
            r_sync_sum  <= '0;
        end else begin
            r_pkt_sum  <= n_pkt_sum;
            r_sync_sum <= n_sync_sum;
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_fe   <= !w_data;
        end
        if (w_load) begin
            r_bytes <= i_q.desc.bytes;
            r_left  <= i_q.desc.nbytes;
            r_cs    <= i_q.desc.cs;
            r_hdr   <= i_q.desc.hdr;
            r_sel   <= i_q.desc.sel;
            r_idx   <= '0;
        end else if (w_emit && w_data) begin
            r_bytes <= r_bytes >> BYTE_W;
            r_left  <= r_left - NB_W'(1);
            r_idx   <= r_idx + NB_W'(1);
        end
    end

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_out_byte;
    assign o_tx.run_last  = r_out_last;
    assign o_tx.frame_end = r_out_fe;

endmodule

@@ hdl/servo_bus_packet_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_framer: servo bus instruction packet framer
// Turns framing requests into a byte stream of FF FF id len body checksum.
// ----------------------------------------------------------------------------
// Each request on i_cmd becomes a run of transmit bytes on o_tx, one byte per
// cycle while o_tx is not stalled: a short packet gives 8 bytes, a position
// write 13, a sync start 7 (8 when it announces no servos), a sync record 7
// (8 on the last record, which carries the checksum), and a record with no
// sync write open gives no bytes at all. run_last marks the final byte of
// each request and frame_end the checksum byte. The byte sequencer sets the
// rate: it sends one byte per cycle from a single output register unless
// o_tx stalls, and a queued request follows the previous one with no gap.
// The decoder accepts a request whenever the queue is not full and queues up
// to two packet descriptors ahead of the sequencer, so new requests are taken
// while bytes of earlier ones are still going out. The first byte of a
// request passes through the queue, the sequencer's byte register and the
// output register. Write the configuration registers (0: write opcode,
// 1: sync opcode, 2: position address) only while no request is in flight.
// ----------------------------------------------------------------------------
module servo_bus_packet_framer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sbpf_in_if.sink                            i_cmd,
    sbpf_out_if.source                         o_tx,
    input  logic                               i_cfg_we,
    input  logic [sbpf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbpf_pkg::BYTE_W-1:0]        i_cfg_data
);
    import sbpf_pkg::*;

    t_cfg   r_cfg;
    logic   w_q_full;
    logic   w_push;
    logic   w_pop;
    t_desc  w_desc;
    t_q_out w_q;

    // Configuration registers: take the write, drop indexes past the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_opcode     <= RST_WRITE_OPCODE;
            r_cfg.sync_opcode      <= RST_SYNC_OPCODE;
            r_cfg.position_address <= RST_POSITION_ADDRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRITE_OPCODE:     r_cfg.write_opcode     <= i_cfg_data;
                CFG_SYNC_OPCODE:      r_cfg.sync_opcode      <= i_cfg_data;
                CFG_POSITION_ADDRESS: r_cfg.position_address <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // Front: decode each request and track the open sync write.
    sbpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_desc   (w_desc)
    );

    // Queue: hold descriptors while the sequencer is busy.
    sbpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_q     (w_q)
    );

    // Back: send bytes, append checksums, register the output.
    sbpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_tx    (o_tx)
    );

endmodule

@@ hdl/sbpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_checker: port checks of the servo bus packet framer
// Watches the output channel for framing and handshake slips.
// ----------------------------------------------------------------------------
module sbpf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [sbpf_pkg::BYTE_W-1:0]   i_tx_byte,
    input  logic                          i_run_last,
    input  logic                          i_frame_end
);
    import sbpf_pkg::*;

    // A checksum byte always closes the request that caused it.
    a_fe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_run_last)
        else $error("frame_end without run_last");

    // Nothing comes out in the cycle after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Hold a stalled byte.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_byte)
            && $stable(i_run_last) && $stable(i_frame_end))
        else $error("stalled byte changed");

endmodule

bind servo_bus_packet_framer sbpf_checker u_sbpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tx.valid),
    .i_out_ready (o_tx.ready),
    .i_tx_byte   (o_tx.tx_byte),
    .i_run_last  (o_tx.run_last),
    .i_frame_end (o_tx.frame_end)
);

@@ tb/sbpf_stream_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_stream_check: byte stream predictor and comparator for the framer
// Watches the request channel, the byte channel and the register write port.
// Keeps its own copy of the registers and the sync write state, works out the
// bytes that each accepted request must produce, and compares every accepted
// byte with the oldest one still due.
// ----------------------------------------------------------------------------
module sbpf_stream_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sbpf_in_if                                i_cmd,
    sbpf_out_if                               i_tx,
    input  logic                              i_cfg_we,
    input  logic [sbpf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbpf_pkg::BYTE_W-1:0]       i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import sbpf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              run_last;
        logic              frame_end;
    } t_tx_byte;

    t_tx_byte          bytes_due[$];
    int                mismatch_count = 0;
    int                byte_idx = 0;

    logic [BYTE_W-1:0] write_opcode;
    logic [BYTE_W-1:0] sync_opcode;
    logic [BYTE_W-1:0] position_address;
    logic [BYTE_W-1:0] sync_sum;
    logic [CNT_W-1:0]  records_left;
    logic              sync_open;

    assign o_fail_count = mismatch_count;

    function automatic t_tx_byte tx_of(input logic [BYTE_W-1:0] b, input logic fe);
        t_tx_byte t;
        t.tx_byte   = b;
        t.run_last  = 1'b0;
        t.frame_end = fe;
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // Work out the bytes of one request and queue them.
    task automatic frame_request(
        input t_action           act,
        input logic [BYTE_W-1:0] id,
        input logic [BYTE_W-1:0] instr,
        input logic [BYTE_W-1:0] addr,
        input logic [BYTE_W-1:0] param,
        input logic [15:0]       pos,
        input logic [15:0]       tim,
        input logic [15:0]       spd,
        input logic [CNT_W-1:0]  count
    );
        t_tx_byte          run[$];
        t_tx_byte          last;
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] csum;
        logic [CNT_W-1:0]  cnt;

        case (act) inside
            ACT_SHORT, ACT_POS: begin
                body.push_back(id);
                if (act == ACT_SHORT) begin
                    body.push_back(SHORT_LEN); body.push_back(instr);
                    body.push_back(addr);      body.push_back(param);
                end else begin
                    body.push_back(POS_LEN);     body.push_back(write_opcode);
                    body.push_back(position_address);
                    body.push_back(pos[15:8]);   body.push_back(pos[7:0]);
                    body.push_back(tim[15:8]);   body.push_back(tim[7:0]);
                    body.push_back(spd[15:8]);   body.push_back(spd[7:0]);
                end
                csum = '0;
                run.push_back(tx_of(HDR_BYTE, 1'b0));
                run.push_back(tx_of(HDR_BYTE, 1'b0));
                foreach (body[i]) begin
                    run.push_back(tx_of(body[i], 1'b0));
                    csum += body[i];
                end
                run.push_back(tx_of(~csum, 1'b1));
            end
            ACT_SSTART: begin
                cnt = (count > CNT_W'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS) : count;
                body.push_back(BROADCAST_ID);
                body.push_back(BYTE_W'(7 * int'(cnt) + int'(SYNC_LEN_BASE)));
                body.push_back(sync_opcode);
                body.push_back(position_address);
                body.push_back(SYNC_DATA_LEN);
                csum = '0;
                run.push_back(tx_of(HDR_BYTE, 1'b0));
                run.push_back(tx_of(HDR_BYTE, 1'b0));
                foreach (body[i]) begin
                    run.push_back(tx_of(body[i], 1'b0));
                    csum += body[i];
                end
                records_left = cnt;
                if (cnt == '0) begin
                    run.push_back(tx_of(~csum, 1'b1));
                    sync_open = 1'b0;
                    sync_sum  = '0;
                end else begin
                    sync_open = 1'b1;
                    sync_sum  = csum;
                end
            end
            ACT_SREC: begin
                // drop a record that no open sync write is waiting for
                if (sync_open && records_left != '0) begin
                    body.push_back(id);
                    body.push_back(pos[15:8]); body.push_back(pos[7:0]);
                    body.push_back(tim[15:8]); body.push_back(tim[7:0]);
                    body.push_back(spd[15:8]); body.push_back(spd[7:0]);
                    csum = sync_sum;
                    foreach (body[i]) begin
                        run.push_back(tx_of(body[i], 1'b0));
                        csum += body[i];
                    end
                    records_left = records_left - CNT_W'(1);
                    if (records_left == '0) begin
                        run.push_back(tx_of(~csum, 1'b1));
                        sync_open = 1'b0;
                        sync_sum  = '0;
                    end else begin
                        sync_sum = csum;
                    end
                end
            end
            default: begin
            end
        endcase

        if (run.size() != 0) begin
            last = run.pop_back();
            last.run_last = 1'b1;
            run.push_back(last);
        end
        foreach (run[i]) bytes_due.push_back(run[i]);
    endtask

    task automatic check_byte(
        input logic [BYTE_W-1:0] got_byte,
        input logic              got_last,
        input logic              got_end
    );
        t_tx_byte want;
        if (bytes_due.size() == 0) begin
            report_mismatch($sformatf("byte %0d: unexpected %02h, nothing due",
                                      byte_idx, got_byte));
        end else begin
            want = bytes_due.pop_front();
            if (got_byte !== want.tx_byte)
                report_mismatch($sformatf("byte %0d: tx_byte %02h, want %02h",
                                          byte_idx, got_byte, want.tx_byte));
            if (got_last !== want.run_last)
                report_mismatch($sformatf("byte %0d: run_last %b, want %b",
                                          byte_idx, got_last, want.run_last));
            if (got_end !== want.frame_end)
                report_mismatch($sformatf("byte %0d: frame_end %b, want %b",
                                          byte_idx, got_end, want.frame_end));
        end
        byte_idx++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            write_opcode     = RST_WRITE_OPCODE;
            sync_opcode      = RST_SYNC_OPCODE;
            position_address = RST_POSITION_ADDRESS;
            sync_sum         = '0;
            records_left     = '0;
            sync_open        = 1'b0;
            bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WRITE_OPCODE:     write_opcode     = i_cfg_data;
                    CFG_SYNC_OPCODE:      sync_opcode      = i_cfg_data;
                    CFG_POSITION_ADDRESS: position_address = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.valid && i_cmd.ready)
                frame_request(t_action'(i_cmd.action), i_cmd.servo_id, i_cmd.instruction,
                              i_cmd.register_address, i_cmd.parameter_byte, i_cmd.position,
                              i_cmd.move_time, i_cmd.speed, i_cmd.servo_count);
            if (i_tx.valid && i_tx.ready)
                check_byte(i_tx.tx_byte, i_tx.run_last, i_tx.frame_end);
        end
        o_pending <= bytes_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench of the servo bus packet framer
// Drives framing requests and register writes into the framer, stalls the
// byte channel at random, and leaves prediction and comparison to the stream
// check beside the framer. Runs a directed set, then random traffic in three
// register settings with different idle patterns, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import sbpf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 8;
    localparam int SETTLE_CYCLES = 16;      // covers the framer's pipeline and dropped records
    localparam int HOLD_CYCLES   = 300;     // long byte channel hold-off
    localparam int PHASE_ITEMS   = 100;
    localparam int LIMIT         = 300000;

    typedef struct packed {
        t_action            action;
        logic [BYTE_W-1:0]  servo_id;
        logic [BYTE_W-1:0]  instruction;
        logic [BYTE_W-1:0]  register_address;
        logic [BYTE_W-1:0]  parameter_byte;
        logic [15:0]        position;
        logic [15:0]        move_time;
        logic [15:0]        speed;
        logic [CNT_W-1:0]   servo_count;
    } t_request;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [BYTE_W-1:0]      cfg_data;
    int                     fail_count;
    int                     pending;

    // Idle odds in percent; changed only between phases.
    int                     send_idle_pct;
    int                     recv_idle_pct;

    // A toggle of stall_token asks the byte channel for one long hold-off.
    logic                   stall_token;
    logic                   stall_ack;
    int                     hold_left;

    sbpf_in_if  cmd_if ();
    sbpf_out_if tx_if ();

    servo_bus_packet_framer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_if),
        .o_tx       (tx_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    sbpf_stream_check u_stream_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_tx         (tx_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Byte channel: hold ready low through a requested hold-off, otherwise
    // drop it at random with the odds of the current phase.
    always @(posedge clk) begin
        if (!rst_n) begin
            tx_if.ready <= 1'b0;
            hold_left   <= 0;
            stall_ack   <= stall_token;
        end else if (stall_ack != stall_token) begin
            stall_ack   <= stall_token;
            hold_left   <= HOLD_CYCLES;
            tx_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            tx_if.ready <= 1'b0;
        end else begin
            tx_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Give up on a hung run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_request make_request(
        input t_action            act,
        input logic [BYTE_W-1:0]  id,
        input logic [BYTE_W-1:0]  instr,
        input logic [BYTE_W-1:0]  addr,
        input logic [BYTE_W-1:0]  param,
        input logic [15:0]        pos,
        input logic [15:0]        tim,
        input logic [15:0]        spd,
        input logic [CNT_W-1:0]   count
    );
        t_request r;
        r.action           = act;
        r.servo_id         = id;
        r.instruction      = instr;
        r.register_address = addr;
        r.parameter_byte   = param;
        r.position         = pos;
        r.move_time        = tim;
        r.speed            = spd;
        r.servo_count      = count;
        return r;
    endfunction

    function automatic t_request random_request(input t_action act);
        return make_request(act, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                            BYTE_W'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            CNT_W'($urandom));
    endfunction

    // Offer one request and return at the edge that accepts it. Valid stays
    // high on return, so back-to-back requests keep it high; it is lowered
    // only for an idle gap or when the traffic pauses.
    task automatic send_request(input t_request r);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.action           <= r.action;
        cmd_if.servo_id         <= r.servo_id;
        cmd_if.instruction      <= r.instruction;
        cmd_if.register_address <= r.register_address;
        cmd_if.parameter_byte   <= r.parameter_byte;
        cmd_if.position         <= r.position;
        cmd_if.move_time        <= r.move_time;
        cmd_if.speed            <= r.speed;
        cmd_if.servo_count      <= r.servo_count;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // Stop offering, wait until every predicted byte is out, then let the
    // pipeline settle so a dropped record cannot still be in flight.
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(
        input logic [BYTE_W-1:0] wr_op,
        input logic [BYTE_W-1:0] sync_op,
        input logic [BYTE_W-1:0] pos_addr
    );
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WRITE_OPCODE;
        cfg_data <= wr_op;
        @(posedge clk);
        cfg_idx  <= CFG_SYNC_OPCODE;
        cfg_data <= sync_op;
        @(posedge clk);
        cfg_idx  <= CFG_POSITION_ADDRESS;
        cfg_data <= pos_addr;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random traffic: mostly complete packets and complete sync writes with
    // random content, plus stray records and sync writes left open.
    task automatic run_random(input int target);
        int       sent;
        int       pick;
        int       count;
        int       recs;
        t_request r;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_request(random_request(ACT_SHORT));
                sent++;
            end else if (pick < 50) begin
                send_request(random_request(ACT_POS));
                sent++;
            end else if (pick < 90) begin
                // well-formed sync write, sometimes empty, sometimes full size
                pick = $urandom_range(99);
                if (pick < 8)
                    count = 0;
                else if (pick < 14)
                    count = $urandom_range(MAX_SERVOS, (1 << CNT_W) - 1);
                else
                    count = $urandom_range(1, 5);
                r = random_request(ACT_SSTART);
                r.servo_count = CNT_W'(count);
                send_request(r);
                sent++;
                recs = (count > MAX_SERVOS) ? MAX_SERVOS : count;
                repeat (recs) begin
                    send_request(random_request(ACT_SREC));
                    sent++;
                end
            end else if ($urandom_range(1) == 0) begin
                // stray record; the framer may well ignore it, so it is not counted
                send_request(random_request(ACT_SREC));
            end else begin
                // sync write left open, to be cut off by whatever comes next
                r = random_request(ACT_SSTART);
                r.servo_count = CNT_W'($urandom_range(2, 6));
                send_request(r);
                sent++;
                repeat ($urandom_range(0, 1)) begin
                    send_request(random_request(ACT_SREC));
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        // Known values on every request and register input from time zero.
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = CFG_WRITE_OPCODE;
        cfg_data                = '0;
        cmd_if.valid            = 1'b0;
        cmd_if.action           = ACT_SHORT;
        cmd_if.servo_id         = '0;
        cmd_if.instruction      = '0;
        cmd_if.register_address = '0;
        cmd_if.parameter_byte   = '0;
        cmd_if.position         = '0;
        cmd_if.move_time        = '0;
        cmd_if.speed            = '0;
        cmd_if.servo_count      = '0;
        stall_token             = 1'b0;
        send_idle_pct           = 38;
        recv_idle_pct           = 49;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the register values left by reset.
        // Extremes of the short packet and the position write.
        send_request(make_request(ACT_SHORT, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, '0));
        send_request(make_request(ACT_SHORT, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F));
        send_request(make_request(ACT_SHORT, 8'hFE, 8'h55, 8'hAA, 8'h5A, '0, '0, '0, '0));
        send_request(make_request(ACT_POS, 8'h00, 8'h00, 8'h00, 8'h00,
                                  16'h0000, 16'hFFFF, 16'h0000, '0));
        send_request(make_request(ACT_POS, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  16'hFFFF, 16'h0000, 16'hFFFF, '0));
        // Record with no sync write open: no bytes at all.
        send_request(make_request(ACT_SREC, 8'h01, 8'h00, 8'h00, 8'h00,
                                  16'h1234, 16'h5678, 16'h9ABC, '0));
        // Sync start announcing no servos: header and checksum at once.
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'd0));
        // Count above the maximum saturates; this sync write is left open.
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'h3F));
        send_request(make_request(ACT_SREC, 8'h01, 8'h00, 8'h00, 8'h00,
                                  16'hAAAA, 16'h5555, 16'h00FF, '0));
        // Short and position packets in the middle of an open sync write.
        send_request(make_request(ACT_SHORT, 8'h07, 8'h02, 8'h38, 8'h02, '0, '0, '0, '0));
        send_request(make_request(ACT_POS, 8'h08, 8'h00, 8'h00, 8'h00,
                                  16'h0800, 16'h0100, 16'h03E8, '0));
        send_request(make_request(ACT_SREC, 8'h02, 8'h00, 8'h00, 8'h00,
                                  16'hFF00, 16'h00FF, 16'h8001, '0));
        // New start abandons the open sync write without its checksum.
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'd1));
        send_request(make_request(ACT_SREC, 8'hFF, 8'h00, 8'h00, 8'h00,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, '0));
        // Nothing open any more: dropped.
        send_request(make_request(ACT_SREC, 8'h03, 8'h00, 8'h00, 8'h00,
                                  16'h0000, 16'h0000, 16'h0000, '0));
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'd2));
        send_request(make_request(ACT_SREC, 8'h00, 8'h00, 8'h00, 8'h00,
                                  16'h0000, 16'h0000, 16'h0000, '0));
        send_request(make_request(ACT_SREC, 8'hFE, 8'h00, 8'h00, 8'h00,
                                  16'h7FFF, 16'h8000, 16'h0001, '0));
        // Just over the maximum, then cut off by an empty sync write.
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'd33));
        send_request(make_request(ACT_SREC, 8'h10, 8'h00, 8'h00, 8'h00,
                                  16'h0102, 16'h0304, 16'h0506, '0));
        send_request(make_request(ACT_SSTART, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 6'd0));

        // Phase 1: registers at zero; sender idles less than receiver.
        wait_idle();
        apply_settings(8'h00, 8'h00, 8'h00);
        run_random(PHASE_ITEMS);

        // Phase 2: registers at all ones; idle odds swapped.
        wait_idle();
        apply_settings(8'hFF, 8'hFF, 8'hFF);
        send_idle_pct = 49;
        recv_idle_pct = 38;
        run_random(PHASE_ITEMS);

        // Phase 3: random registers, no idling, and one long hold-off on the
        // byte channel so the framer fills up and stalls its request input.
        wait_idle();
        apply_settings(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_token <= ~stall_token;
        run_random(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
